FILE: design/rcfo_pkg.sv
`default_nettype none

package rcfo_pkg;

  localparam int unsigned NumCh    = 16;
  localparam int unsigned ChIdxW   = 4;
  localparam int unsigned ChW      = 16;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned KindW    = 2;

  localparam logic [KindW-1:0] KIND_CMP  = 2'd0;
  localparam logic [KindW-1:0] KIND_SBUS = 2'd1;
  localparam logic [KindW-1:0] KIND_PPM  = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic MODE_PWM    = 1'b0;
  localparam logic MODE_SERIAL = 1'b1;

  localparam logic [3:0] SBUS_LAST_PHASE = 4'd8;   // frame every 9th tick
  localparam logic [4:0] PPM_LAST_PHASE  = 5'd21;  // frame every 22nd tick

  localparam logic [SlotW-1:0] SBUS_LAST_DATA_BYTE = 5'd22;
  localparam logic [SlotW-1:0] SBUS_FLAGS_BYTE     = 5'd23;
  localparam logic [SlotW-1:0] SBUS_END_BYTE       = 5'd24;
  localparam logic [SlotW-1:0] PPM_LAST_CH_SLOT    = 5'd7;
  localparam logic [SlotW-1:0] PPM_RSSI_SLOT       = 5'd8;
  localparam logic [SlotW-1:0] PPM_REM_SLOT        = 5'd9;
  localparam logic [4:0]       SBUS_RSSI_FIELD     = 5'd15;

  // Source of the value carried by an emitted result.
  typedef enum logic [2:0] {
    SRC_CH,
    SRC_LEVEL,
    SRC_SYNC,
    SRC_SBUS,
    SRC_FLAGS,
    SRC_ZERO,
    SRC_RSSI,
    SRC_REM
  } src_e;

  typedef struct packed {
    logic              ch_wr;
    logic              tick_start;
    logic              emit;
    logic [KindW-1:0]  kind;
    logic [SlotW-1:0]  slot;
    src_e              src;
    logic              last;
    logic [ChIdxW-1:0] rd_idx;
    logic              acc_clr;
    logic              acc_load;
    logic              fld_rssi;
    logic              rem_upd;
    logic              rem_first;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic acc_ge8;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/rc_channel_frame_output.sv
`default_nettype none

// Receiver channel output encoder. Write beats (tuser = 0) store one 16-bit
// channel width. A tick beat (tuser = 1) produces its results one per clock
// through a single output register while the output is ready, but not during
// the 16 field loads of the SBUS bit packer: 5 results in PWM mode and 2 in
// serial mode, plus 25 bytes when an SBUS frame is due and 10 more when a
// PPM frame is due. The input is ready only when the controller is idle; the
// final result of a tick may still wait in the output register while the
// next beat is taken. The mode register is always ready; the user must
// write it only between ticks, as the block itself does not enforce this.
module rc_channel_frame_output (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] channel_index, [19:4] channel_value, [27:20] rssi, [35:28] miss_count
  input  wire logic [39:0] s_axis_tdata,
  // [0] opcode
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [4:0] slot, [20:5] value
  output logic [23:0]      m_axis_tdata,
  // [1:0] kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  rcfo_pkg::cmd_t cmd;
  rcfo_pkg::sts_t sts;
  logic [rcfo_pkg::SlotW-1:0] out_slot;
  logic [rcfo_pkg::ChW-1:0]   out_value;

  rcfo_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .in_opcode_i   (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  rcfo_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_index_i  (s_axis_tdata[3:0]),
    .in_value_i  (s_axis_tdata[19:4]),
    .in_rssi_i   (s_axis_tdata[27:20]),
    .in_miss_i   (s_axis_tdata[35:28]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_slot_o  (out_slot),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, out_value, out_slot};

endmodule

`default_nettype wire

FILE: design/rcfo_ctrl.sv
`default_nettype none

module rcfo_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic          in_opcode_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_data_i,
  input  wire rcfo_pkg::sts_t sts_i,
  output rcfo_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CMP      = 4'd1;
  localparam logic [3:0] ST_SB_HDR   = 4'd2;
  localparam logic [3:0] ST_SB_BODY  = 4'd3;
  localparam logic [3:0] ST_SB_FLAGS = 4'd4;
  localparam logic [3:0] ST_SB_END   = 4'd5;
  localparam logic [3:0] ST_PPM_CH   = 4'd6;
  localparam logic [3:0] ST_PPM_RS   = 4'd7;
  localparam logic [3:0] ST_PPM_REM  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [4:0] fld_q, fld_d;
  logic [3:0] sphase_q, sphase_d;
  logic [4:0] pphase_q, pphase_d;
  logic       sb_due_q, sb_due_d;
  logic       pp_due_q, pp_due_d;
  logic       mode_q;
  logic       go;
  logic       fin;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign go            = sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      fld_q    <= '0;
      sphase_q <= '0;
      pphase_q <= '0;
      sb_due_q <= 1'b0;
      pp_due_q <= 1'b0;
      mode_q   <= rcfo_pkg::MODE_PWM;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      fld_q    <= fld_d;
      sphase_q <= sphase_d;
      pphase_q <= pphase_d;
      sb_due_q <= sb_due_d;
      pp_due_q <= pp_due_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    cmd_o    = '0;
    cmd_o.src = rcfo_pkg::SRC_ZERO;
    state_d  = state_q;
    cnt_d    = cnt_q;
    fld_d    = fld_q;
    sphase_d = sphase_q;
    pphase_d = pphase_q;
    sb_due_d = sb_due_q;
    pp_due_d = pp_due_q;
    fin      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_opcode_i == rcfo_pkg::OP_WRITE) begin
            cmd_o.ch_wr = 1'b1;
          end else begin
            cmd_o.tick_start = 1'b1;
            sb_due_d = (sphase_q == rcfo_pkg::SBUS_LAST_PHASE);
            pp_due_d = (pphase_q == rcfo_pkg::PPM_LAST_PHASE);
            sphase_d = sb_due_d ? 4'd0 : sphase_q + 4'd1;
            pphase_d = pp_due_d ? 5'd0 : pphase_q + 5'd1;
            cnt_d    = '0;
            state_d  = ST_CMP;
          end
        end
      end

      ST_CMP: begin
        cmd_o.kind = rcfo_pkg::KIND_CMP;
        cmd_o.slot = cnt_q;
        cmd_o.src  = rcfo_pkg::SRC_CH;
        if (mode_q == rcfo_pkg::MODE_PWM) begin
          cmd_o.rd_idx = cnt_q[3:0];
          fin = (cnt_q == 5'd4);
          if (fin) begin
            cmd_o.src = rcfo_pkg::SRC_LEVEL;
          end
          cmd_o.last = fin;
        end else begin
          cmd_o.rd_idx = cnt_q[3:0] + 4'd2;
          fin = (cnt_q == 5'd1);
          cmd_o.last = fin && !sb_due_q && !pp_due_q;
        end
        cmd_o.emit = go;
        if (go) begin
          if (fin) begin
            cnt_d = '0;
            if (mode_q == rcfo_pkg::MODE_PWM) begin
              state_d = ST_IDLE;
            end else if (sb_due_q) begin
              state_d = ST_SB_HDR;
            end else if (pp_due_q) begin
              state_d = ST_PPM_CH;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
      end

      ST_SB_HDR: begin
        // Channel 0 is read here so its scaled width is ready for the first load.
        cmd_o.kind    = rcfo_pkg::KIND_SBUS;
        cmd_o.slot    = '0;
        cmd_o.src     = rcfo_pkg::SRC_SYNC;
        cmd_o.rd_idx  = '0;
        cmd_o.acc_clr = 1'b1;
        cmd_o.emit    = go;
        if (go) begin
          cnt_d   = 5'd1;
          fld_d   = '0;
          state_d = ST_SB_BODY;
        end
      end

      ST_SB_BODY: begin
        cmd_o.kind     = rcfo_pkg::KIND_SBUS;
        cmd_o.slot     = cnt_q;
        cmd_o.src      = rcfo_pkg::SRC_SBUS;
        cmd_o.rd_idx   = fld_q[3:0];
        cmd_o.fld_rssi = (fld_q == rcfo_pkg::SBUS_RSSI_FIELD);
        if (!sts_i.acc_ge8) begin
          // A load always leaves at least eight bits, so a byte is sent next, once the
          // output is free, while the next channel's scaled width settles.
          cmd_o.acc_load = 1'b1;
          fld_d = fld_q + 5'd1;
        end else begin
          cmd_o.emit = go;
          if (go) begin
            if (cnt_q == rcfo_pkg::SBUS_LAST_DATA_BYTE) begin
              cnt_d   = rcfo_pkg::SBUS_FLAGS_BYTE;
              state_d = ST_SB_FLAGS;
            end else begin
              cnt_d = cnt_q + 5'd1;
            end
          end
        end
      end

      ST_SB_FLAGS: begin
        cmd_o.kind = rcfo_pkg::KIND_SBUS;
        cmd_o.slot = rcfo_pkg::SBUS_FLAGS_BYTE;
        cmd_o.src  = rcfo_pkg::SRC_FLAGS;
        cmd_o.emit = go;
        if (go) begin
          state_d = ST_SB_END;
        end
      end

      ST_SB_END: begin
        cmd_o.kind = rcfo_pkg::KIND_SBUS;
        cmd_o.slot = rcfo_pkg::SBUS_END_BYTE;
        cmd_o.src  = rcfo_pkg::SRC_ZERO;
        cmd_o.last = !pp_due_q;
        cmd_o.emit = go;
        if (go) begin
          cnt_d   = '0;
          state_d = pp_due_q ? ST_PPM_CH : ST_IDLE;
        end
      end

      ST_PPM_CH: begin
        cmd_o.kind      = rcfo_pkg::KIND_PPM;
        cmd_o.slot      = cnt_q;
        cmd_o.src       = rcfo_pkg::SRC_CH;
        cmd_o.rd_idx    = cnt_q[3:0];
        cmd_o.rem_first = (cnt_q == 5'd0);
        cmd_o.emit      = go;
        cmd_o.rem_upd   = go;
        if (go) begin
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == rcfo_pkg::PPM_LAST_CH_SLOT) begin
            state_d = ST_PPM_RS;
          end
        end
      end

      ST_PPM_RS: begin
        cmd_o.kind = rcfo_pkg::KIND_PPM;
        cmd_o.slot = rcfo_pkg::PPM_RSSI_SLOT;
        cmd_o.src  = rcfo_pkg::SRC_RSSI;
        cmd_o.emit = go;
        if (go) begin
          state_d = ST_PPM_REM;
        end
      end

      ST_PPM_REM: begin
        cmd_o.kind = rcfo_pkg::KIND_PPM;
        cmd_o.slot = rcfo_pkg::PPM_REM_SLOT;
        cmd_o.src  = rcfo_pkg::SRC_REM;
        cmd_o.last = 1'b1;
        cmd_o.emit = go;
        if (go) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/rcfo_dpath.sv
`default_nettype none

module rcfo_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rcfo_pkg::cmd_t                cmd_i,
  output rcfo_pkg::sts_t                     sts_o,
  input  wire logic [rcfo_pkg::ChIdxW-1:0]   in_index_i,
  input  wire logic [rcfo_pkg::ChW-1:0]      in_value_i,
  input  wire logic [7:0]                    in_rssi_i,
  input  wire logic [7:0]                    in_miss_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rcfo_pkg::KindW-1:0]         out_kind_o,
  output logic [rcfo_pkg::SlotW-1:0]         out_slot_o,
  output logic [rcfo_pkg::ChW-1:0]           out_value_o,
  output logic                               out_last_o
);

  logic [rcfo_pkg::ChW-1:0] chan_q [rcfo_pkg::NumCh];
  logic [rcfo_pkg::ChW-1:0] rd_ch;
  logic [7:0]  rssi_q;
  logic [7:0]  miss_q;

  // floor(w * 8 / 5) as w * ceil(2^22 / 5) >> 19, exact for 16-bit w.
  logic [35:0] prod;
  logic [16:0] quo_q;
  logic [16:0] quo_diff;
  logic [10:0] fld_ch;
  logic [11:0] rssi_sum;
  logic [10:0] fld_rssi;
  logic [10:0] field;

  logic [18:0] acc_q, acc_d;
  logic [4:0]  bits_q, bits_d;

  logic [rcfo_pkg::ChW-1:0] thr;
  logic [rcfo_pkg::ChW-1:0] level;
  logic [rcfo_pkg::ChW-1:0] rs;
  logic [rcfo_pkg::ChW-1:0] rem_q;
  logic [rcfo_pkg::ChW-1:0] rem_base;
  logic [rcfo_pkg::ChW-1:0] flags;
  logic [rcfo_pkg::ChW-1:0] val;

  assign rd_ch = chan_q[cmd_i.rd_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rcfo_pkg::NumCh; i++) begin
        chan_q[i] <= (i == 2) ? 16'd1000 : 16'd1500;
      end
    end else if (cmd_i.ch_wr) begin
      chan_q[in_index_i] <= in_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      rssi_q <= in_rssi_i;
      miss_q <= in_miss_i;
    end
  end

  assign prod = {20'd0, rd_ch} * 36'd838861;

  always_ff @(posedge clk_i) begin
    quo_q <= prod[35:19];
  end

  assign quo_diff = quo_q - 17'd1408;
  always_comb begin
    if (quo_q < 17'd1408) begin
      fld_ch = '0;
    end else if (quo_diff > 17'd2047) begin
      fld_ch = 11'd2047;
    end else begin
      fld_ch = quo_diff[10:0];
    end
  end

  assign rssi_sum = {rssi_q, 4'd0} + 12'd208;
  assign fld_rssi = (rssi_q > 8'd114) ? 11'd2047 : rssi_sum[10:0];
  assign field    = cmd_i.fld_rssi ? fld_rssi : fld_ch;

  // Bit packer: fields enter above the bits still held, bytes leave from the bottom.
  always_comb begin
    acc_d  = acc_q;
    bits_d = bits_q;
    if (cmd_i.acc_clr) begin
      acc_d  = '0;
      bits_d = '0;
    end else if (cmd_i.acc_load) begin
      acc_d  = acc_q | ({8'd0, field} << bits_q);
      bits_d = bits_q + 5'd11;
    end else if (cmd_i.emit && (cmd_i.src == rcfo_pkg::SRC_SBUS)) begin
      acc_d  = acc_q >> 8;
      bits_d = bits_q - 5'd8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      bits_q <= '0;
    end else begin
      acc_q  <= acc_d;
      bits_q <= bits_d;
    end
  end

  assign thr = chan_q[2];
  always_comb begin
    if (thr > 16'd2000) begin
      level = 16'd1000;
    end else if (thr > 16'd1050) begin
      level = thr - 16'd1000;
    end else begin
      level = '0;
    end
  end

  assign rs = (rssi_q > 8'd100) ? 16'd2000
            : ({5'd0, rssi_q, 3'd0} + {7'd0, rssi_q, 1'd0} + 16'd1000);

  assign rem_base = cmd_i.rem_first ? 16'd22000 : rem_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rem_upd) begin
      rem_q <= rem_base - rd_ch;
    end
  end

  assign flags = {12'd0, (miss_q > 8'd47), (miss_q > 8'd2), 2'd0};

  always_comb begin
    unique case (cmd_i.src)
      rcfo_pkg::SRC_CH:    val = rd_ch;
      rcfo_pkg::SRC_LEVEL: val = level;
      rcfo_pkg::SRC_SYNC:  val = 16'h000F;
      rcfo_pkg::SRC_SBUS:  val = {8'd0, acc_q[7:0]};
      rcfo_pkg::SRC_FLAGS: val = flags;
      rcfo_pkg::SRC_ZERO:  val = '0;
      rcfo_pkg::SRC_RSSI:  val = rs;
      rcfo_pkg::SRC_REM:   val = rem_q - rs;
      default:             val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_o  <= cmd_i.kind;
      out_slot_o  <= cmd_i.slot;
      out_value_o <= val;
      out_last_o  <= cmd_i.last;
    end
  end

  assign sts_o.out_free = !out_valid_o || out_ready_i;
  assign sts_o.acc_ge8  = (bits_q >= 5'd8);

endmodule

`default_nettype wire

FILE: bench/tb_rc_channel_frame_output.sv
`default_nettype none

module tb_rc_channel_frame_output;
  import rcfo_pkg::*;

  typedef struct packed {
    logic              op;
    logic [ChIdxW-1:0] idx;
    logic [ChW-1:0]    width;
    logic [7:0]        rssi;
    logic [7:0]        miss;
  } in_beat_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SlotW-1:0] slot;
    logic [15:0]      value;
    logic             last;
  } out_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = MODE_PWM;

  // Predictor state: channel widths, the two frame counters and the mode.
  logic [ChW-1:0] ch_width [NumCh];
  logic [3:0]     sbus_count;
  logic [4:0]     ppm_count;
  logic           mode_q;

  in_beat_t  stim_q [$];
  out_beat_t owed_q [$];
  in_beat_t  tx_beat;
  int        tx_gap = 0;
  int        rx_gap = 0;
  logic      tx_calm = 1'b0;
  logic      rx_calm = 1'b0;
  logic      hold_arm = 1'b0;
  int        hold_left = 0;
  int        ticks_sent = 0;
  int        fails = 0;

  rc_channel_frame_output i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("tb_rc_channel_frame_output failed");
    $finish;
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic out_beat_t mk(input logic [KindW-1:0] kind, input int slot,
                                   input logic [15:0] value);
    out_beat_t r;
    r.kind  = kind;
    r.slot  = SlotW'(slot);
    r.value = value;
    r.last  = 1'b0;
    return r;
  endfunction

  // Updates the channel store on a write beat; on a tick beat it queues the
  // compare values and any SBUS and PPM frames that fall due.
  task automatic apply_beat(input in_beat_t b);
    out_beat_t    res [$];
    out_beat_t    tail;
    logic         sbus_due;
    logic         ppm_due;
    logic [175:0] stream;
    logic [31:0]  scaled;
    logic [10:0]  fld;
    logic [15:0]  remain;
    logic [15:0]  rs;
    logic [15:0]  thr;
    int           k;
    if (b.op == OP_WRITE) begin
      ch_width[b.idx] = b.width;
    end else begin
      sbus_due = (sbus_count == SBUS_LAST_PHASE);
      sbus_count = sbus_due ? 4'd0 : sbus_count + 4'd1;
      ppm_due = (ppm_count == PPM_LAST_PHASE);
      ppm_count = ppm_due ? 5'd0 : ppm_count + 5'd1;
      if (mode_q == MODE_PWM) begin
        for (k = 0; k < 4; k++) res.push_back(mk(KIND_CMP, k, ch_width[k]));
        thr = ch_width[2];
        res.push_back(mk(KIND_CMP, 4, (thr > 16'd2000) ? 16'd1000 :
                                      (thr > 16'd1050) ? thr - 16'd1000 : 16'd0));
      end else begin
        res.push_back(mk(KIND_CMP, 0, ch_width[2]));
        res.push_back(mk(KIND_CMP, 1, ch_width[3]));
        if (sbus_due) begin
          stream = '0;
          for (k = 0; k < 15; k++) begin
            scaled = (32'(ch_width[k]) * 32'd8) / 32'd5;
            if (scaled < 32'd1408) fld = 11'd0;
            else if (scaled - 32'd1408 > 32'd2047) fld = 11'd2047;
            else fld = 11'(scaled - 32'd1408);
            stream[11*k +: 11] = fld;
          end
          stream[11*SBUS_RSSI_FIELD +: 11] = (b.rssi > 8'd114) ? 11'd2047 :
                                             11'(32'(b.rssi) * 16 + 208);
          res.push_back(mk(KIND_SBUS, 0, 16'h000F));
          for (k = 1; k <= SBUS_LAST_DATA_BYTE; k++)
            res.push_back(mk(KIND_SBUS, k, {8'h00, stream[8*(k-1) +: 8]}));
          res.push_back(mk(KIND_SBUS, SBUS_FLAGS_BYTE,
                           ((b.miss > 8'd47) ? 16'h0008 : 16'h0000) |
                           ((b.miss > 8'd2) ? 16'h0004 : 16'h0000)));
          res.push_back(mk(KIND_SBUS, SBUS_END_BYTE, 16'h0000));
        end
        if (ppm_due) begin
          remain = 16'd22000;
          for (k = 0; k <= PPM_LAST_CH_SLOT; k++) begin
            remain = remain - ch_width[k];
            res.push_back(mk(KIND_PPM, k, ch_width[k]));
          end
          rs = (b.rssi > 8'd100) ? 16'd2000 : 16'(32'(b.rssi) * 10 + 1000);
          res.push_back(mk(KIND_PPM, PPM_RSSI_SLOT, rs));
          res.push_back(mk(KIND_PPM, PPM_REM_SLOT, remain - rs));
        end
      end
      tail = res.pop_back();
      tail.last = 1'b1;
      res.push_back(tail);
      foreach (res[k]) owed_q.push_back(res[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_WRITE;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_beat(tx_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          tx_beat = stim_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0000, tx_beat.miss, tx_beat.rssi, tx_beat.width, tx_beat.idx};
          s_axis_tuser  <= tx_beat.op;
          tx_gap = tx_calm ? 0 : idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once by the stimulus.
  always @(posedge clk_i) begin
    if (hold_arm) hold_left <= 600;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t got;
    out_beat_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = m_axis_tuser;
        got.slot  = m_axis_tdata[4:0];
        got.value = m_axis_tdata[20:5];
        got.last  = m_axis_tlast;
        if (owed_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected beat: kind %0d slot %0d value %0d last %0b",
                     got.kind, got.slot, got.value, got.last);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (got.kind !== want.kind || got.slot !== want.slot ||
              got.value !== want.value || got.last !== want.last) begin
            if (fails < 10)
              $display("mismatch: got kind %0d slot %0d value %0d last %0b, %s %0d %0d %0d %0b",
                       got.kind, got.slot, got.value, got.last, "expected",
                       want.kind, want.slot, want.value, want.last);
            fails++;
          end
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_gap = idle_len();
      end
    end
  end

  task automatic add_write(input int idx, input int width);
    in_beat_t b;
    b.op    = OP_WRITE;
    b.idx   = ChIdxW'(idx);
    b.width = ChW'(width);
    b.rssi  = 8'($urandom);
    b.miss  = 8'($urandom);
    stim_q.push_back(b);
  endtask

  task automatic add_tick(input int rssi, input int miss);
    in_beat_t b;
    b.op    = OP_TICK;
    b.idx   = ChIdxW'($urandom);
    b.width = ChW'($urandom);
    b.rssi  = 8'(rssi);
    b.miss  = 8'(miss);
    stim_q.push_back(b);
    ticks_sent++;
  endtask

  task automatic add_random(input int tick_pct);
    in_beat_t b;
    b.op  = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_WRITE;
    b.idx = ChIdxW'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0:       b.width = 16'h0000;
      1:       b.width = 16'hFFFF;
      2, 3:    b.width = ChW'($urandom_range(800, 2200));
      default: b.width = ChW'($urandom);
    endcase
    b.rssi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(95, 120)) : 8'($urandom);
    b.miss = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 50)) : 8'($urandom);
    stim_q.push_back(b);
    if (b.op == OP_TICK) ticks_sent++;
  endtask

  // Returns on a falling edge once every beat is sent and every result is in.
  task automatic settle();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || s_axis_tvalid || owed_q.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_q = m;
    @(negedge clk_i);
  endtask

  initial begin
    int p;
    int n;
    int target;
    for (n = 0; n < NumCh; n++) ch_width[n] = 16'd1500;
    ch_width[2] = 16'd1000;
    sbus_count = '0;
    ppm_count  = '0;
    mode_q     = MODE_PWM;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // PWM mode out of reset, throttle thresholds and width extremes.
    add_tick(0, 0);
    add_write(2, 2001);
    add_tick(255, 255);
    add_write(2, 1051);
    add_tick(0, 0);
    add_write(2, 1050);
    add_tick(0, 0);
    add_write(0, 0);
    add_write(1, 65535);
    add_write(3, 2000);
    add_tick(0, 0);
    settle();

    // Serial mode; the fourth tick here is the ninth overall and carries SBUS.
    write_mode(MODE_SERIAL);
    add_write(4, 65535);
    add_write(5, 65535);
    add_tick(0, 0);
    add_tick(255, 255);
    add_tick(114, 2);
    add_tick(115, 3);
    settle();

    for (p = 0; p < 5; p++) begin
      tx_calm = (p == 2);
      rx_calm = (p == 2) || (p == 4);
      write_mode((p == 0 || p == 2) ? MODE_PWM : MODE_SERIAL);
      for (n = 0; n < 26; n++) add_random(60);
      if (p == 1) begin
        @(posedge clk_i);
        hold_arm <= 1'b1;
        @(posedge clk_i);
        hold_arm <= 1'b0;
      end
      settle();
    end

    // Run on in serial mode until a tick where a PPM frame falls due.
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    write_mode(MODE_SERIAL);
    target = (ticks_sent / 22 + 1) * 22;
    while (ticks_sent < target) add_random(90);
    settle();
    repeat (60) @(posedge clk_i);

    if (fails == 0 && owed_q.size() == 0) begin
      $display("tb_rc_channel_frame_output passed");
    end else begin
      $display("tb_rc_channel_frame_output failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
